// ----- hdl/e2rm_pkg.sv -----
// Package for the Euler-angle to rotation-matrix pipeline.
// Holds widths, sine polynomial constants, payload types and rounding helpers.
// No dependencies.
package e2rm_pkg;

  // Binary angle width (full turn = 2^ANGLE_BITS) and output fraction bits
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int ENTRY_W    = 16;
  localparam int QF         = ANGLE_BITS - 2;   // fraction bits of a quarter turn

  // Sine polynomial: Q2.30 internal arithmetic
  localparam int TH_W   = 31;                   // theta, < pi/2 in Q2.30
  localparam int T2_W   = 32;                   // theta^2
  localparam int TERM_W = 31;                   // Horner term, <= 1.0
  localparam int P_W    = T2_W + TERM_W;
  localparam int N_W    = 32;
  localparam int RCP_W  = 34;
  localparam int M_W    = N_W + RCP_W;
  localparam int RCP_SH = 36;
  localparam int Q_W    = M_W - RCP_SH;
  localparam int DEN_W  = 8;
  localparam int ITERS  = 7;
  localparam int LANES  = 6;                    // sin-part and cos-part per angle
  localparam int ONE_SH = 30;
  localparam int TF_SH  = ONE_SH - FRAC_BITS;

  localparam logic [TH_W-1:0]   HALF_PI_Q30 = 31'd1686629713;
  localparam logic [TERM_W-1:0] ONE_Q30     = TERM_W'(1) << ONE_SH;
  localparam logic signed [ENTRY_W-1:0] ONE_F = ENTRY_W'(1) << FRAC_BITS;

  // Horner divisors 2k(2k+1), k = 7 down to 1, and floor(2^36 / den)
  localparam logic [DEN_W-1:0] DEN [ITERS] = '{
    8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [RCP_W-1:0] RECIP [ITERS] = '{
    34'd327235603, 34'd440509466, 34'd624722515, 34'd954437176,
    34'd1636178017, 34'd3435973836, 34'd11453246122
  };

  typedef struct packed {
    logic signed [ENTRY_W-1:0] x_angle;
    logic signed [ENTRY_W-1:0] y_angle;
    logic signed [ENTRY_W-1:0] z_angle;
  } angles_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] r00;
    logic signed [ENTRY_W-1:0] r01;
    logic signed [ENTRY_W-1:0] r02;
    logic signed [ENTRY_W-1:0] r10;
    logic signed [ENTRY_W-1:0] r11;
    logic signed [ENTRY_W-1:0] r12;
    logic signed [ENTRY_W-1:0] r20;
    logic signed [ENTRY_W-1:0] r21;
    logic signed [ENTRY_W-1:0] r22;
  } matrix_t;

  // Q2.30 magnitude to Q1.F, round half up, clamp to 1.0
  function automatic logic signed [ENTRY_W-1:0] to_frac(input logic [TH_W-1:0] s);
    logic [TH_W:0] w;
    logic [ENTRY_W-1:0] v;
    w = {1'b0, s} + ((TH_W+1)'(1) << (TF_SH - 1));
    v = ENTRY_W'(w >> TF_SH);
    if (v > ONE_F) v = ONE_F;
    return v;
  endfunction

  // Round half up of a Q2.2F value to Q1.F (floor after adding half)
  function automatic logic signed [2*ENTRY_W:0] round_f(input logic signed [2*ENTRY_W:0] v);
    logic signed [2*ENTRY_W:0] w;
    w = v + ((2*ENTRY_W+1)'(1) << (FRAC_BITS - 1));
    return w >>> FRAC_BITS;
  endfunction

  // Clamp to -1.0..1.0
  function automatic logic signed [ENTRY_W-1:0] sat_f(input logic signed [2*ENTRY_W:0] v);
    logic signed [2*ENTRY_W:0] one;
    one = (2*ENTRY_W+1)'(ONE_F);
    if (v > one)  return ONE_F;
    if (v < -one) return -ONE_F;
    return ENTRY_W'(v);
  endfunction

endpackage

// ----- hdl/e2rm_if.sv -----
// Valid/ready channel interfaces for the angle input and matrix output.
// Depends on e2rm_pkg for the payload types.
interface e2rm_angle_if;
  logic              valid;
  logic              ready;
  e2rm_pkg::angles_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface e2rm_matrix_if;
  logic              valid;
  logic              ready;
  e2rm_pkg::matrix_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/euler_to_rotation_matrix.sv -----
// Euler angles (binary, 65536 per turn) in, Z-Y-X rotation matrix in Q1.14 out.
// Depends on e2rm_pkg and the channel interfaces in e2rm_if.sv.
//
// Fully pipelined: one angle triple is taken per cycle unless the output
// stalls. The pipeline depth is set by the sine evaluation (seven Horner steps
// of three stages each: multiply, reciprocal multiply, divide correction),
// plus angle scaling, squaring, final multiply, quadrant fold and two stages
// of matrix products. Six sine units run in parallel (sin and cos of each
// angle). A stall at the output freezes the whole pipeline; nothing is lost.
module euler_to_rotation_matrix (
  input  logic                 clk,
  input  logic                 rst,
  e2rm_angle_if.sink           angles,
  e2rm_matrix_if.source        matrix
);

  localparam int NSTG = 3 * e2rm_pkg::ITERS + 6;
  localparam int QD   = 3 * e2rm_pkg::ITERS + 3;
  localparam int LIT  = 3 * e2rm_pkg::ITERS;
  localparam int EW   = e2rm_pkg::ENTRY_W;

  logic            adv;
  logic [NSTG-1:0] vld;

  // Angle front end
  logic [e2rm_pkg::QF-1:0]  rfrac [3];
  logic [e2rm_pkg::QF:0]    xf    [e2rm_pkg::LANES];
  logic [1:0]               quad  [QD][3];

  logic [e2rm_pkg::TH_W-1:0]   th1  [e2rm_pkg::LANES];
  logic [e2rm_pkg::TH_W-1:0]   th2  [e2rm_pkg::LANES];
  logic [e2rm_pkg::T2_W-1:0]   t22  [e2rm_pkg::LANES];

  // Horner stages
  logic [e2rm_pkg::P_W-1:0]    pa   [e2rm_pkg::LANES][e2rm_pkg::ITERS];
  logic [e2rm_pkg::N_W-1:0]    nb   [e2rm_pkg::LANES][e2rm_pkg::ITERS];
  logic [e2rm_pkg::M_W-1:0]    mb   [e2rm_pkg::LANES][e2rm_pkg::ITERS];
  logic [e2rm_pkg::TERM_W-1:0] tc   [e2rm_pkg::LANES][e2rm_pkg::ITERS];
  logic [e2rm_pkg::TH_W-1:0]   tha  [e2rm_pkg::LANES][LIT];
  logic [e2rm_pkg::T2_W-1:0]   t2a  [e2rm_pkg::LANES][LIT];

  logic [e2rm_pkg::TH_W-1:0]   sq   [e2rm_pkg::LANES];
  logic signed [EW-1:0]        sn   [3];
  logic signed [EW-1:0]        cs   [3];

  logic signed [EW-1:0] p_sx, p_cx, p_sy, p_sz, p_cz;
  logic signed [EW-1:0] czsy, szsy, e00, e10, e20, e21, e22;
  e2rm_pkg::matrix_t    mout;

  // Global advance: the pipeline moves when the output slot is free or taken
  assign adv          = !vld[NSTG-1] || matrix.ready;
  assign angles.ready = adv;
  assign matrix.valid = vld[NSTG-1];
  assign matrix.data  = mout;

  // Quarter-turn fractions: sin lane uses r, cos lane uses one quarter minus r
  always_comb begin
    rfrac[0] = angles.data.x_angle[e2rm_pkg::QF-1:0];
    rfrac[1] = angles.data.y_angle[e2rm_pkg::QF-1:0];
    rfrac[2] = angles.data.z_angle[e2rm_pkg::QF-1:0];
    for (int a = 0; a < 3; a++) begin
      xf[2*a]   = {1'b0, rfrac[a]};
      xf[2*a+1] = ((e2rm_pkg::QF+1)'(1) << e2rm_pkg::QF) - {1'b0, rfrac[a]};
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], angles.valid};
    end
  end

  // Sine datapath
  always_ff @(posedge clk) begin
    logic [e2rm_pkg::QF+e2rm_pkg::TH_W:0] thp;
    logic [2*e2rm_pkg::TH_W-1:0]          sqp;
    logic [e2rm_pkg::TH_W-1:0]            thi;
    logic [e2rm_pkg::T2_W-1:0]            t2i;
    logic [e2rm_pkg::TERM_W-1:0]          tmi;
    logic [e2rm_pkg::Q_W-1:0]             q0;
    logic [e2rm_pkg::Q_W-1:0]             q;
    logic [e2rm_pkg::Q_W+e2rm_pkg::DEN_W-1:0] qd;
    logic [e2rm_pkg::N_W:0]               rem;
    logic signed [EW-1:0]                 va, vb;
    if (adv) begin
      // Quadrant travels alongside the sine lanes
      quad[0][0] <= angles.data.x_angle[e2rm_pkg::ANGLE_BITS-1 -: 2];
      quad[0][1] <= angles.data.y_angle[e2rm_pkg::ANGLE_BITS-1 -: 2];
      quad[0][2] <= angles.data.z_angle[e2rm_pkg::ANGLE_BITS-1 -: 2];
      for (int i = 1; i < QD; i++) quad[i] <= quad[i-1];

      for (int l = 0; l < e2rm_pkg::LANES; l++) begin
        // Scale to radians in Q2.30
        thp = xf[l] * e2rm_pkg::HALF_PI_Q30;
        th1[l] <= e2rm_pkg::TH_W'(thp >> e2rm_pkg::QF);
        // Square
        sqp = th1[l] * th1[l];
        th2[l] <= th1[l];
        t22[l] <= e2rm_pkg::T2_W'(sqp >> e2rm_pkg::ONE_SH);

        // Horner steps: term = 1 - (t2*term)/den
        for (int k = 0; k < e2rm_pkg::ITERS; k++) begin
          if (k == 0) begin
            thi = th2[l];
            t2i = t22[l];
            tmi = e2rm_pkg::ONE_Q30;
          end else begin
            thi = tha[l][3*k-1];
            t2i = t2a[l][3*k-1];
            tmi = tc[l][k-1];
          end
          pa[l][k]      <= t2i * tmi;
          tha[l][3*k]   <= thi;
          t2a[l][3*k]   <= t2i;

          nb[l][k]      <= e2rm_pkg::N_W'(pa[l][k] >> e2rm_pkg::ONE_SH);
          mb[l][k]      <= (pa[l][k] >> e2rm_pkg::ONE_SH) * e2rm_pkg::RECIP[k];
          tha[l][3*k+1] <= tha[l][3*k];
          t2a[l][3*k+1] <= t2a[l][3*k];

          q0  = mb[l][k][e2rm_pkg::M_W-1:e2rm_pkg::RCP_SH];
          qd  = q0 * e2rm_pkg::DEN[k];
          rem = {1'b0, nb[l][k]} - (e2rm_pkg::N_W+1)'(qd);
          q   = (rem >= (e2rm_pkg::N_W+1)'(e2rm_pkg::DEN[k])) ? q0 + 1'b1 : q0;
          tc[l][k]      <= e2rm_pkg::TERM_W'(e2rm_pkg::ONE_Q30 - e2rm_pkg::TERM_W'(q));
          tha[l][3*k+2] <= tha[l][3*k+1];
          t2a[l][3*k+2] <= t2a[l][3*k+1];
        end

        // Final multiply by theta
        sqp = tha[l][LIT-1] * tc[l][e2rm_pkg::ITERS-1];
        sq[l] <= e2rm_pkg::TH_W'(sqp >> e2rm_pkg::ONE_SH);
      end

      // Round to Q1.F and fold by quadrant
      for (int a = 0; a < 3; a++) begin
        va = e2rm_pkg::to_frac(sq[2*a]);
        vb = e2rm_pkg::to_frac(sq[2*a+1]);
        case (quad[QD-1][a])
          2'd0:    begin sn[a] <= va;  cs[a] <= vb;  end
          2'd1:    begin sn[a] <= vb;  cs[a] <= -va; end
          2'd2:    begin sn[a] <= -va; cs[a] <= -vb; end
          default: begin sn[a] <= -vb; cs[a] <= va;  end
        endcase
      end
    end
  end

  // Matrix products: first level, then sums, rounding and clamp
  always_ff @(posedge clk) begin
    logic signed [2*EW:0] a0, a1;
    if (adv) begin
      p_sx <= sn[0];
      p_cx <= cs[0];
      p_sy <= sn[1];
      p_sz <= sn[2];
      p_cz <= cs[2];
      czsy <= EW'(e2rm_pkg::round_f((2*EW+1)'(cs[2] * sn[1])));
      szsy <= EW'(e2rm_pkg::round_f((2*EW+1)'(sn[2] * sn[1])));
      e00  <= e2rm_pkg::sat_f(e2rm_pkg::round_f((2*EW+1)'(cs[2] * cs[1])));
      e10  <= e2rm_pkg::sat_f(e2rm_pkg::round_f((2*EW+1)'(sn[2] * cs[1])));
      e20  <= e2rm_pkg::sat_f(-(2*EW+1)'(sn[1]));
      e21  <= e2rm_pkg::sat_f(e2rm_pkg::round_f((2*EW+1)'(cs[1] * sn[0])));
      e22  <= e2rm_pkg::sat_f(e2rm_pkg::round_f((2*EW+1)'(cs[1] * cs[0])));

      mout.r00 <= e00;
      mout.r10 <= e10;
      mout.r20 <= e20;
      mout.r21 <= e21;
      mout.r22 <= e22;
      a0 = (2*EW+1)'(czsy * p_sx) - (2*EW+1)'(p_sz * p_cx);
      mout.r01 <= e2rm_pkg::sat_f(e2rm_pkg::round_f(a0));
      a1 = (2*EW+1)'(czsy * p_cx) + (2*EW+1)'(p_sz * p_sx);
      mout.r02 <= e2rm_pkg::sat_f(e2rm_pkg::round_f(a1));
      a0 = (2*EW+1)'(szsy * p_sx) + (2*EW+1)'(p_cz * p_cx);
      mout.r11 <= e2rm_pkg::sat_f(e2rm_pkg::round_f(a0));
      a1 = (2*EW+1)'(szsy * p_cx) - (2*EW+1)'(p_cz * p_sx);
      mout.r12 <= e2rm_pkg::sat_f(e2rm_pkg::round_f(a1));
    end
  end

endmodule
